// ===== design/llat_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the life-like automaton block.
package llat_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int GEN_W      = 32;

  localparam logic [8:0] BIRTH_RST   = 9'd8;
  localparam logic [8:0] SURVIVE_RST = 9'd12;
  localparam logic [6:0] DIM_RST     = 7'd64;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIRTH   = 2'd0,
    CFG_SURVIVE = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC,
    S_LD_CUR,
    S_LD_DN,
    S_LD_NX,
    S_CELL,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    req_t       req_type;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       cell_value;
  } in_req_t;

  typedef struct packed {
    logic             cell_state;
    logic [GEN_W-1:0] generation;
  } out_res_t;

  typedef struct packed {
    logic [8:0] birth_mask;
    logic [8:0] survive_mask;
  } rule_cfg_t;

  // 3x3 neighborhood, columns ordered left, center, right
  typedef struct packed {
    logic [2:0] up;
    logic [2:0] mid;
    logic [2:0] dn;
  } win_t;

endpackage

// ===== design/llat_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module llat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== design/llat_rule_unit.sv =====
`timescale 1ns / 1ps
// Neighbor count and birth/survival rule lookup for one cell.
module llat_rule_unit (
  input  llat_pkg::win_t      win,
  input  llat_pkg::rule_cfg_t cfg,
  output logic                alive_nxt
);
  import llat_pkg::*;

  logic [3:0] count;
  logic       self_alive;

  assign self_alive = win.mid[1];

  assign count = {3'd0, win.up[0]}  + {3'd0, win.up[1]}  + {3'd0, win.up[2]}
               + {3'd0, win.mid[0]} + {3'd0, win.mid[2]}
               + {3'd0, win.dn[0]}  + {3'd0, win.dn[1]}  + {3'd0, win.dn[2]};

  // count never exceeds 8, so the index stays inside the 9-bit masks
  assign alive_nxt = self_alive ? cfg.survive_mask[count] : cfg.birth_mask[count];

endmodule

// ===== design/llat_seq.sv =====
`timescale 1ns / 1ps
// Request sequencer: grid clearing, cell access and row-by-row generation sweep.
module llat_seq #(
  parameter int MAX_WIDTH  = llat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = llat_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  llat_pkg::in_req_t   in_data,
  input  llat_pkg::rule_cfg_t rule_cfg,
  input  logic [CW-1:0]       wlast,
  input  logic [RW-1:0]       hlast,
  input  logic                res_take,
  output logic                res_valid,
  output llat_pkg::out_res_t  res_data
);
  import llat_pkg::*;

  seq_state_t       state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CW-1:0]    x_r, x_nxt;
  logic [RW-1:0]    y_r, y_nxt;
  logic             v_r, v_nxt;
  logic             cell_r, cell_nxt;
  logic [GEN_W-1:0] gen_r, gen_nxt;

  logic [MAX_WIDTH-1:0] prev_r, prev_nxt;
  logic [MAX_WIDTH-1:0] cur_r, cur_nxt;
  logic [MAX_WIDTH-1:0] dn_r, dn_nxt;
  logic [MAX_WIDTH-1:0] first_r, first_nxt;
  logic [MAX_WIDTH-1:0] new_r, new_nxt;

  logic                 ram_we;
  logic [RW-1:0]        ram_waddr;
  logic [MAX_WIDTH-1:0] ram_wdata;
  logic                 ram_re;
  logic [RW-1:0]        ram_raddr;
  logic [MAX_WIDTH-1:0] ram_rdata;

  logic                 in_inside;
  logic [CW-1:0]        xl, xr;
  win_t                 win;
  logic                 alive_nxt;
  logic [MAX_WIDTH-1:0] row_mod;
  logic [MAX_WIDTH-1:0] row_new;

  llat_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  llat_rule_unit u_rule (
    .win       (win),
    .cfg       (rule_cfg),
    .alive_nxt (alive_nxt)
  );

  assign in_inside = (32'(in_data.cell_x) <= 32'(wlast)) &&
                     (32'(in_data.cell_y) <= 32'(hlast));

  // wrap columns at the active width
  assign xl = (x_r == '0)    ? wlast : x_r - 1'b1;
  assign xr = (x_r == wlast) ? '0    : x_r + 1'b1;

  assign win.up  = {prev_r[xl], prev_r[x_r], prev_r[xr]};
  assign win.mid = {cur_r[xl],  cur_r[x_r],  cur_r[xr]};
  assign win.dn  = {dn_r[xl],   dn_r[x_r],   dn_r[xr]};

  always_comb begin
    row_mod      = ram_rdata;
    row_mod[x_r] = v_r;
    row_new      = new_r;
    row_new[x_r] = alive_nxt;
  end

  assign res_data.cell_state = cell_r;
  assign res_data.generation = gen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      y_r     <= '0;
      gen_r   <= '0;
    end else begin
      state_r <= state_nxt;
      y_r     <= y_nxt;
      gen_r   <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    x_r     <= x_nxt;
    v_r     <= v_nxt;
    cell_r  <= cell_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    dn_r    <= dn_nxt;
    first_r <= first_nxt;
    new_r   <= new_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    v_nxt     = v_r;
    cell_nxt  = cell_r;
    gen_nxt   = gen_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    dn_nxt    = dn_r;
    first_nxt = first_r;
    new_nxt   = new_r;
    ram_we    = 1'b0;
    ram_waddr = y_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    in_stall  = 1'b1;
    res_valid = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (y_r == RW'(MAX_HEIGHT - 1)) begin
          y_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          y_nxt = y_r + 1'b1;
        end
      end

      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt  = in_data.req_type;
          x_nxt    = CW'(in_data.cell_x);
          y_nxt    = RW'(in_data.cell_y);
          v_nxt    = in_data.cell_value;
          cell_nxt = 1'b0;
          unique case (in_data.req_type)
            REQ_WRITE, REQ_READ: begin
              if (in_inside) begin
                ram_re    = 1'b1;
                ram_raddr = RW'(in_data.cell_y);
                state_nxt = S_ACC;
              end else begin
                state_nxt = S_FIN;
              end
            end
            REQ_STEP: begin
              ram_re    = 1'b1;
              ram_raddr = hlast;
              state_nxt = S_LD_CUR;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_ACC: begin
        if (req_r == REQ_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = row_mod;
          cell_nxt  = v_r;
        end else begin
          cell_nxt = ram_rdata[x_r];
        end
        state_nxt = S_FIN;
      end

      S_LD_CUR: begin
        prev_nxt  = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = S_LD_DN;
      end

      S_LD_DN: begin
        cur_nxt   = ram_rdata;
        first_nxt = ram_rdata;
        new_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = (hlast == '0) ? '0 : RW'(1);
        y_nxt     = '0;
        state_nxt = S_LD_NX;
      end

      S_LD_NX: begin
        // last row wraps down to the saved copy of the old first row
        dn_nxt    = (y_r == hlast) ? first_r : ram_rdata;
        x_nxt     = '0;
        state_nxt = S_CELL;
      end

      S_CELL: begin
        new_nxt = row_new;
        if (x_r == wlast) begin
          ram_we    = 1'b1;
          ram_wdata = row_new;
          if (y_r == hlast) begin
            gen_nxt   = gen_r + 1'b1;
            cell_nxt  = 1'b0;
            state_nxt = S_FIN;
          end else begin
            prev_nxt  = cur_r;
            cur_nxt   = dn_r;
            new_nxt   = dn_r;
            y_nxt     = y_r + 1'b1;
            ram_re    = ((RW+1)'(y_r) + (RW+1)'(1)) != (RW+1)'(hlast);
            ram_raddr = RW'((RW+1)'(y_r) + (RW+1)'(2));
            state_nxt = S_LD_NX;
          end
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end

      S_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

endmodule

// ===== design/life_like_automaton_torus_top.sv =====
`timescale 1ns / 1ps
// Top level of the toroidal life-like cellular automaton.
//
// Life-like automaton on a torus of MAX_HEIGHT rows by MAX_WIDTH columns, of which the
// top-left grid_height by grid_width cells are in use; the grid lives in a RAM with one
// row per word. One request is worked on at a time and in_stall stays high until its
// result is loaded into the output register. A cell write or read passes through the
// accept, RAM row read and finish states; a write is a read-modify-write of its row.
// A write or read outside the area in use, and the unused request code, go straight
// from accept to finish. An advance loads the last and first rows, then for each row
// of the active area loads the row below into the three-row window and sweeps its
// cells: a single neighbor-count and rule unit handles one cell per clock. The RAM
// read port sets that per-row load. After reset the block clears the grid, one row
// per cycle, with in_stall high; configuration writes are taken throughout.
module life_like_automaton_torus_top #(
  parameter int MAX_WIDTH  = llat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = llat_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  llat_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output llat_pkg::out_res_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [llat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [llat_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import llat_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // configuration registers
  logic [8:0] birth_r, birth_nxt;
  logic [8:0] survive_r, survive_nxt;
  logic [6:0] width_r, width_nxt;
  logic [6:0] height_r, height_nxt;

  rule_cfg_t     rule_cfg;
  logic [CW-1:0] wlast;
  logic [RW-1:0] hlast;

  // output register
  logic     out_valid_r, out_valid_nxt;
  out_res_t out_data_r, out_data_nxt;

  logic     res_take;
  logic     res_valid;
  out_res_t res_data;

  always_comb begin
    birth_nxt   = birth_r;
    survive_nxt = survive_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BIRTH:   birth_nxt   = cfg_wdata;
        CFG_SURVIVE: survive_nxt = cfg_wdata;
        CFG_WIDTH:   width_nxt   = cfg_wdata[6:0];
        CFG_HEIGHT:  height_nxt  = cfg_wdata[6:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_r   <= BIRTH_RST;
      survive_r <= SURVIVE_RST;
      width_r   <= DIM_RST;
      height_r  <= DIM_RST;
    end else begin
      birth_r   <= birth_nxt;
      survive_r <= survive_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
    end
  end

  assign rule_cfg.birth_mask   = birth_r;
  assign rule_cfg.survive_mask = survive_r;

  // Clamp the active area to 1..MAX and hand down the last index in use.
  always_comb begin
    if (width_r == '0) begin
      wlast = '0;
    end else if (32'(width_r) > MAX_WIDTH) begin
      wlast = CW'(MAX_WIDTH - 1);
    end else begin
      wlast = CW'(width_r - 7'd1);
    end
    if (height_r == '0) begin
      hlast = '0;
    end else if (32'(height_r) > MAX_HEIGHT) begin
      hlast = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast = RW'(height_r - 7'd1);
    end
  end

  llat_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .rule_cfg  (rule_cfg),
    .wlast     (wlast),
    .hlast     (hlast),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Take a finished result when the output register is empty or being drained.
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
